/* rtl/core/hlcd_pkg.sv */
// ----------------------------------------------------------------------------
// hlcd_pkg
// Shared types and constants for the header/length/checksum deframer.
// ----------------------------------------------------------------------------
package hlcd_pkg;

  // Value of both header bytes.
  localparam logic [7:0] HDR_BYTE = 8'hFF;

  // Frame end status codes.
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_CSUM_ERR = 2'd1;
  localparam logic [1:0] ST_HDR_ERR  = 2'd2;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic [1:0] frame_status;
  } result_t;

endpackage

/* rtl/core/hlcd_in_stage.sv */
// ----------------------------------------------------------------------------
// hlcd_in_stage
// Input register: captures one byte per transfer and holds it until the
// parser has consumed it.
// ----------------------------------------------------------------------------
module hlcd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // The register can take a new byte when it is empty or being emptied.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

/* rtl/core/hlcd_parser.sv */
// ----------------------------------------------------------------------------
// hlcd_parser
// Frame state machine: header hunt, length, payload with running sum and
// checksum compare. One byte is consumed per step.
// ----------------------------------------------------------------------------
module hlcd_parser
  import hlcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_HDR2  = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] count_dec;

  assign count_dec = count_q - 8'd1;

  // Next state and result for the byte at hand.
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    res_o       = '{out_byte: 8'd0, frame_end: 1'b0, frame_status: ST_GOOD};
    unique case (phase_q)
      PH_HDR2: begin
        if (byte_i == HDR_BYTE) begin
          phase_d = PH_LEN;
        end else begin
          phase_d                = PH_HUNT;
          res_valid_o            = 1'b1;
          res_o.frame_end        = 1'b1;
          res_o.frame_status     = ST_HDR_ERR;
        end
      end
      PH_LEN: begin
        count_d = byte_i;
        sum_d   = 8'd0;
        phase_d = (byte_i == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        sum_d          = sum_q + byte_i;
        count_d        = count_dec;
        if (count_dec == 8'd0) begin
          phase_d = PH_CHECK;
        end
        res_valid_o    = 1'b1;
        res_o.out_byte = byte_i;
      end
      PH_CHECK: begin
        phase_d            = PH_HUNT;
        count_d            = 8'd0;
        sum_d              = 8'd0;
        res_valid_o        = 1'b1;
        res_o.out_byte     = byte_i;
        res_o.frame_end    = 1'b1;
        res_o.frame_status = (byte_i == ~sum_q) ? ST_GOOD : ST_CSUM_ERR;
      end
      default: begin
        // Hunting; unused codes behave the same.
        phase_d = (byte_i == HDR_BYTE) ? PH_HDR2 : PH_HUNT;
      end
    endcase
  end

  // State registers advance only when a byte is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= 8'd0;
      sum_q   <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

`ifndef SYNTHESIS
  // In the payload phase at least one byte is always still to come.
  a_data_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> count_q != 8'd0)
    else $error("payload phase with zero remaining count");

  // Payload results always carry a good status.
  a_payload_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && !res_o.frame_end |-> res_o.frame_status == ST_GOOD)
    else $error("payload result with non-zero status");

  // A checksum byte returns the parser to hunting with a cleared sum.
  a_check_return : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_CHECK |=> phase_q == PH_HUNT && sum_q == 8'd0)
    else $error("parser did not return to hunting after checksum");
`endif

endmodule

/* rtl/core/hlcd_out_reg.sv */
// ----------------------------------------------------------------------------
// hlcd_out_reg
// Result register: holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module hlcd_out_reg
  import hlcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    res_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic [1:0] frame_status_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held result leaves this cycle.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (free_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = res_q.out_byte;
  assign frame_end_o    = res_q.frame_end;
  assign frame_status_o = res_q.frame_status;

endmodule

/* rtl/core/header_length_checksum_deframer.sv */
// ----------------------------------------------------------------------------
// header_length_checksum_deframer
// Byte stream deframer for header/length/payload/checksum frames.
// ----------------------------------------------------------------------------
// Input channel: one received byte per transfer (in_valid_i, in_stall_o,
// in_byte_i). A frame is two 0xFF header bytes, a length byte, that many
// payload bytes and a checksum byte equal to the inverse of the 8-bit sum
// of the payload. Bytes outside a frame are dropped without a result.
// Output channel: one result per payload byte (frame_end_o low), and one
// end result per frame (frame_end_o high) carrying the checksum byte and
// a status of good or checksum mismatch. A bad second header byte gives
// an end result with a header error status and a zero byte.
// A byte is held in the input register and its result in the result register.
// Throughput: one byte per cycle while the receiver does not stall; the
// input register, the combinational parser step and the result register
// form a two-stage pipeline. A receiver stall while a result is held holds
// both registers and, with a byte held, raises in_stall_o in the same cycle.
// Reset clears both pipeline stages and puts the parser into header hunt.
// ----------------------------------------------------------------------------
module header_length_checksum_deframer
  import hlcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic [1:0] frame_status_o
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_free;
  logic       step;
  logic       res_valid;
  result_t    res;

  // A held byte is consumed whenever the result register can take its result.
  assign step = s1_valid && out_free;

  hlcd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (step),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  hlcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s1_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hlcd_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (step && res_valid),
    .res_i          (res),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .frame_end_o    (frame_end_o),
    .frame_status_o (frame_status_o)
  );

endmodule
